// ----- hw/rtl/pvt_pkg.sv -----
// Shared widths, codes, constants and types of the PCM volume and tone stage.
package pvt_pkg;

   localparam int PHASE_WIDTH = 32;
   localparam int COUNT_WIDTH = 24;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int FUNC_WIDTH      = 2;
   localparam int VOLUME_WIDTH    = 7;
   localparam int STEP_WIDTH      = 32;
   localparam int LENGTH_WIDTH    = 24;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [FUNC_WIDTH-1:0] FUNC_PCM     = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_TONE    = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_RESTART = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOLUME      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MONO_MODE   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_STEP  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TONE_LENGTH = 3'd3;

   localparam logic [VOLUME_WIDTH-1:0] FULL_SCALE_PERCENT = 7'd100;
   localparam logic [VOLUME_WIDTH-1:0] RESET_VOLUME       = 7'd50;
   localparam logic [STEP_WIDTH-1:0]   RESET_STEP         = 32'd39370533;
   localparam logic [LENGTH_WIDTH-1:0] RESET_LENGTH       = 24'd96000;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [FUNC_WIDTH-1:0]          func_type;

   localparam sample_type TONE_HIGH = 16'sd6000;
   localparam sample_type TONE_LOW  = -16'sd6000;

   // Product of a sample and a gain of at most 100 has magnitude below 2^22;
   // divide it by 100 through an exact reciprocal.
   localparam int PRODUCT_WIDTH = 24;
   localparam int MAG_WIDTH     = 22;
   localparam int RECIP_WIDTH   = 23;
   localparam int RECIP_SHIFT   = 29;
   localparam int QUOT_WIDTH    = MAG_WIDTH + RECIP_WIDTH;
   localparam logic [RECIP_WIDTH-1:0] RECIP_100 = 23'd5368710;

   typedef logic [MAG_WIDTH-1:0] mag_type;

   typedef struct packed {
      logic [VOLUME_WIDTH-1:0] volume;
      logic                    mono_mode;
      logic [STEP_WIDTH-1:0]   tone_phase_step;
      logic [LENGTH_WIDTH-1:0] tone_length;
   } cfg_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       done;
   } frame_type;

endpackage

// ----- hw/rtl/pvt_req_if.sv -----
// Request channel carrying one frame command per transaction.
interface pvt_req_if import pvt_pkg::*; ();
   logic       valid;
   logic       ready;
   func_type   func;
   sample_type left_in;
   sample_type right_in;

   modport source(output valid, func, left_in, right_in, input ready);
   modport sink(input valid, func, left_in, right_in, output ready);
endinterface

// ----- hw/rtl/pvt_rsp_if.sv -----
// Response channel carrying one scaled stereo frame per transaction.
interface pvt_rsp_if import pvt_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type left_out;
   sample_type right_out;
   logic       tone_done;

   modport source(output valid, left_out, right_out, tone_done, input ready);
   modport sink(input valid, left_out, right_out, tone_done, output ready);
endinterface

// ----- hw/rtl/pvt_csr_regs.sv -----
// Configuration registers with volume saturation.
module pvt_csr_regs import pvt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data,
   output cfg_type                    cfg
);

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic [VOLUME_WIDTH-1:0] volume_wr;

   assign volume_wr = csr_wr_data[VOLUME_WIDTH-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VOLUME: begin
               cfg_in.volume = (volume_wr > FULL_SCALE_PERCENT) ? FULL_SCALE_PERCENT
                                                                : volume_wr;
            end
            CSR_MONO_MODE:   cfg_in.mono_mode       = csr_wr_data[0];
            CSR_PHASE_STEP:  cfg_in.tone_phase_step = csr_wr_data[STEP_WIDTH-1:0];
            CSR_TONE_LENGTH: cfg_in.tone_length     = csr_wr_data[LENGTH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volume          <= RESET_VOLUME;
         cfg_ff.mono_mode       <= 1'b0;
         cfg_ff.tone_phase_step <= RESET_STEP;
         cfg_ff.tone_length     <= RESET_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/pvt_tone_front.sv -----
// Command decode, tone accumulator, frame counter and input register.
module pvt_tone_front import pvt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   pvt_req_if.sink   req_chan,
   output logic      frame_valid,
   output frame_type frame,
   input  logic      frame_ready
);

   logic [PHASE_WIDTH-1:0] phase_ff;
   logic [PHASE_WIDTH-1:0] phase_in;
   logic [PHASE_WIDTH-1:0] phase_adv;
   logic [COUNT_WIDTH-1:0] frames_ff;
   logic [COUNT_WIDTH-1:0] frames_in;
   logic                   frame_valid_ff;
   logic                   frame_valid_in;
   frame_type              frame_ff;
   frame_type              frame_in;
   logic                   accept;
   logic                   load;

   assign req_chan.ready = !frame_valid_ff || frame_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign phase_adv      = phase_ff + PHASE_WIDTH'(cfg.tone_phase_step);

   always_comb begin
      phase_in  = phase_ff;
      frames_in = frames_ff;
      frame_in  = frame_ff;
      load      = 1'b0;
      if (accept) begin
         unique case (req_chan.func)
            FUNC_PCM: begin
               load           = 1'b1;
               frame_in.left  = req_chan.left_in;
               frame_in.right = cfg.mono_mode ? req_chan.left_in : req_chan.right_in;
               frame_in.done  = 1'b0;
            end
            FUNC_TONE: begin
               load = 1'b1;
               if (frames_ff == '0) begin
                  frame_in.left  = '0;
                  frame_in.right = '0;
                  frame_in.done  = 1'b1;
               end else begin
                  phase_in       = phase_adv;
                  frames_in      = frames_ff - COUNT_WIDTH'(1);
                  frame_in.left  = phase_adv[PHASE_WIDTH-1] ? TONE_HIGH : TONE_LOW;
                  frame_in.right = phase_adv[PHASE_WIDTH-1] ? TONE_HIGH : TONE_LOW;
                  frame_in.done  = (frames_ff == COUNT_WIDTH'(1));
               end
            end
            FUNC_RESTART: begin
               frames_in = COUNT_WIDTH'(cfg.tone_length);
               phase_in  = '0;
            end
            default: ;
         endcase
      end
      frame_valid_in = req_chan.ready ? load : frame_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         frames_ff      <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         frames_ff      <= frames_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

endmodule

// ----- hw/rtl/pvt_gain_scale.sv -----
// Gain multiply, divide by 100 and result register.
module pvt_gain_scale import pvt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [VOLUME_WIDTH-1:0] volume,
   input  logic                    frame_valid,
   input  frame_type               frame,
   output logic                    frame_ready,
   pvt_rsp_if.source               rsp_chan
);

   function automatic logic signed [PRODUCT_WIDTH-1:0] gain_product(
      input sample_type              sample,
      input logic [VOLUME_WIDTH-1:0] gain
   );
      logic signed [PRODUCT_WIDTH-1:0] s_ext;
      logic signed [PRODUCT_WIDTH-1:0] g_ext;
      s_ext = PRODUCT_WIDTH'(sample);
      g_ext = $signed({{(PRODUCT_WIDTH-VOLUME_WIDTH){1'b0}}, gain});
      return s_ext * g_ext;
   endfunction

   function automatic mag_type magnitude(input logic signed [PRODUCT_WIDTH-1:0] p);
      logic signed [PRODUCT_WIDTH-1:0] neg;
      neg = -p;
      return p[PRODUCT_WIDTH-1] ? neg[MAG_WIDTH-1:0] : p[MAG_WIDTH-1:0];
   endfunction

   function automatic sample_type divide_100(input mag_type mag, input logic neg);
      logic [QUOT_WIDTH-1:0]   full;
      logic [SAMPLE_WIDTH-1:0] quot;
      logic [SAMPLE_WIDTH-1:0] quot_neg;
      full     = QUOT_WIDTH'(mag) * QUOT_WIDTH'(RECIP_100);
      quot     = full[RECIP_SHIFT +: SAMPLE_WIDTH];
      quot_neg = -quot;
      return neg ? $signed(quot_neg) : $signed(quot);
   endfunction

   logic                            prod_valid_ff;
   logic                            prod_valid_in;
   logic signed [PRODUCT_WIDTH-1:0] prod_left;
   logic signed [PRODUCT_WIDTH-1:0] prod_right;
   mag_type                         mag_left_ff;
   mag_type                         mag_right_ff;
   logic                            neg_left_ff;
   logic                            neg_right_ff;
   logic                            done_prod_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   sample_type                      left_out_ff;
   sample_type                      right_out_ff;
   logic                            tone_done_ff;
   logic                            out_ready;

   assign out_ready   = !rsp_valid_ff || rsp_chan.ready;
   assign frame_ready = !prod_valid_ff || out_ready;

   assign prod_left  = gain_product(frame.left, volume);
   assign prod_right = gain_product(frame.right, volume);

   assign prod_valid_in = frame_ready ? frame_valid : prod_valid_ff;
   assign rsp_valid_in  = out_ready ? prod_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_ready && frame_valid) begin
         mag_left_ff  <= magnitude(prod_left);
         mag_right_ff <= magnitude(prod_right);
         neg_left_ff  <= prod_left[PRODUCT_WIDTH-1];
         neg_right_ff <= prod_right[PRODUCT_WIDTH-1];
         done_prod_ff <= frame.done;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && prod_valid_ff) begin
         left_out_ff  <= divide_100(mag_left_ff, neg_left_ff);
         right_out_ff <= divide_100(mag_right_ff, neg_right_ff);
         tone_done_ff <= done_prod_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.left_out  = left_out_ff;
   assign rsp_chan.right_out = right_out_ff;
   assign rsp_chan.tone_done = tone_done_ff;

endmodule

// ----- hw/rtl/pcm_volume_and_tone_stage_top.sv -----
// Top level of the PCM volume and test-tone output stage.
//
// req_chan takes one command per transaction: a PCM frame, a tone frame or
// a tone restart. PCM and tone frames each give one response on rsp_chan;
// a restart, or an unused command code, gives none.
// csr_wr_en writes csr_wr_data into the register chosen by csr_index
// (volume, mono mode, phase step, tone length); write only while idle.
// The response passes the input register, the gain multiply register and
// the divide-by-100 into the result register. Throughput: one transaction
// per cycle while rsp_chan is not stalled; each of the three stages
// advances whenever the stage after it is free or empties that cycle.
// Reset clears the tone phase and frame counter, empties the pipeline and
// loads volume 50, stereo, a 440 Hz step at 48 kHz and 96000 tone frames.
// When rsp_chan stalls, each stage holds its frame; req_chan keeps
// accepting until every stage is full, then ready drops.
module pcm_volume_and_tone_stage_top import pvt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   pvt_req_if.sink                    req_chan,
   pvt_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   cfg_type   cfg;
   logic      frame_valid;
   logic      frame_ready;
   frame_type frame;

   pvt_csr_regs u_csr_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   pvt_tone_front u_tone_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_chan    (req_chan),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_ready (frame_ready)
   );

   pvt_gain_scale u_gain_scale (
      .clock       (clock),
      .reset       (reset),
      .volume      (cfg.volume),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_ready (frame_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ----- sim/pcm_volume_and_tone_stage_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the PCM volume and tone stage: directed table, then random frame and tone bursts.
module pcm_volume_and_tone_stage_top_tb;
   import pvt_pkg::*;

   localparam func_type FUNC_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   localparam int RESET_CYCLES    = 9;
   localparam int IDLE_PERCENT    = 9;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 6;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 230;
   localparam int STEADY_PHASE    = 4;
   localparam int SQUEEZE_PHASE   = 5;
   localparam int MAX_REPORTS     = 10;

   typedef enum bit {ROW_FRAME, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
      func_type                   func;
      sample_type                 left;
      sample_type                 right;
      bit                         known;
      frame_type                  want;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;

   pvt_req_if req_chan ();
   pvt_rsp_if rsp_chan ();

   pcm_volume_and_tone_stage_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor copy of registers and tone state
   logic [VOLUME_WIDTH-1:0] gain_pct;
   logic                    mono_on;
   logic [PHASE_WIDTH-1:0]  tone_incr;
   logic [COUNT_WIDTH-1:0]  tone_len;
   logic [PHASE_WIDTH-1:0]  tone_phase;
   logic [COUNT_WIDTH-1:0]  frames_left;

   frame_type    pending_frames[$];
   stim_row_type directed_rows[$];
   int           mismatches  = 0;
   int           cycle_count = 0;
   bit           steady      = 1'b0;
   bit           hold_rsp    = 1'b0;

   always #4 clock = ~clock;

   function automatic sample_type apply_gain(int s);
      return sample_type'((s * int'(gain_pct)) / int'(FULL_SCALE_PERCENT));
   endfunction

   function automatic bit predict_frame(func_type f, sample_type l, sample_type r,
                                        output frame_type res);
      sample_type tone;
      res = '0;
      case (f)
         FUNC_PCM: begin
            res.left  = apply_gain(l);
            res.right = mono_on ? res.left : apply_gain(r);
            return 1'b1;
         end
         FUNC_TONE: begin
            if (frames_left == '0) begin
               res.done = 1'b1;
               return 1'b1;
            end
            tone_phase  = tone_phase + tone_incr;
            tone        = tone_phase[PHASE_WIDTH-1] ? TONE_HIGH : TONE_LOW;
            res.left    = apply_gain(tone);
            res.right   = res.left;
            frames_left = frames_left - COUNT_WIDTH'(1);
            res.done    = (frames_left == '0);
            return 1'b1;
         end
         FUNC_RESTART: begin
            frames_left = tone_len;
            tone_phase  = '0;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic sample_type pick_sample();
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      return sample_type'($urandom);
   endfunction

   function automatic void add_frame(func_type f, sample_type l, sample_type r);
      stim_row_type row;
      row.kind  = ROW_FRAME;
      row.index = '0;
      row.data  = '0;
      row.func  = f;
      row.left  = l;
      row.right = r;
      row.known = 1'b0;
      row.want  = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(func_type f, sample_type l, sample_type r,
                                       sample_type wl, sample_type wr, bit wd);
      add_frame(f, l, r);
      directed_rows[$].known     = 1'b1;
      directed_rows[$].want.left  = wl;
      directed_rows[$].want.right = wr;
      directed_rows[$].want.done  = wd;
   endfunction

   function automatic void add_csr(logic [CSR_INDEX_WIDTH-1:0] idx,
                                   logic [CSR_DATA_WIDTH-1:0] value);
      stim_row_type row;
      row.kind  = ROW_CSR;
      row.index = idx;
      row.data  = value;
      row.func  = FUNC_PCM;
      row.left  = '0;
      row.right = '0;
      row.known = 1'b0;
      row.want  = '0;
      directed_rows.push_back(row);
   endfunction

   task automatic send_frame(func_type f, sample_type l, sample_type r,
                             bit known = 1'b0, frame_type want = '0);
      frame_type predicted;
      bit        emits;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.func     <= f;
      req_chan.left_in  <= l;
      req_chan.right_in <= r;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      emits = predict_frame(f, l, r, predicted);
      if (emits)
         pending_frames.push_back(known ? want : predicted);
   endtask

   task automatic drain_block();
      req_chan.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx,
                            logic [CSR_DATA_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_VOLUME:
            gain_pct = (value[VOLUME_WIDTH-1:0] > FULL_SCALE_PERCENT) ?
                       FULL_SCALE_PERCENT : value[VOLUME_WIDTH-1:0];
         CSR_MONO_MODE:   mono_on   = value[0];
         CSR_PHASE_STEP:  tone_incr = value[PHASE_WIDTH-1:0];
         CSR_TONE_LENGTH: tone_len  = value[COUNT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic run_random_phase(int phase);
      logic [VOLUME_WIDTH-1:0] vol;
      logic                    mono;
      logic [STEP_WIDTH-1:0]   step;
      logic [LENGTH_WIDTH-1:0] len;
      int                      budget;
      int                      pick;
      int                      burst;
      drain_block();
      vol  = VOLUME_WIDTH'($urandom_range(0, 127));
      mono = 1'($urandom_range(0, 1));
      step = $urandom;
      len  = LENGTH_WIDTH'($urandom_range(0, 40));
      case (phase)
         0: begin vol = 7'd0;   mono = 1'b0; step = 32'hFFFF_FFFF; len = '0; end
         1: begin vol = 7'd100; mono = 1'b1; step = '0; end
         2: begin vol = 7'h7F;  mono = 1'b0; step = 32'h8000_0000; end
         3: len = 24'hFF_FFFF;
         default: ;
      endcase
      write_csr(CSR_VOLUME, {25'($urandom), vol});
      write_csr(CSR_MONO_MODE, {31'($urandom), mono});
      write_csr(CSR_PHASE_STEP, step);
      write_csr(CSR_TONE_LENGTH, {8'($urandom), len});
      write_csr(3'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), $urandom);
      steady   = (phase == STEADY_PHASE);
      hold_rsp = (phase == SQUEEZE_PHASE);
      budget   = ITEMS_PER_PHASE;
      while (budget > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            burst = (tone_len > 40) ? $urandom_range(1, 48)
                                    : int'(tone_len) + $urandom_range(0, 3);
            send_frame(FUNC_RESTART, pick_sample(), pick_sample());
            repeat (burst) send_frame(FUNC_TONE, pick_sample(), pick_sample());
            budget -= 1 + burst;
         end else if (pick < 80) begin
            send_frame(FUNC_PCM, pick_sample(), pick_sample());
            budget--;
         end else if (pick < 92) begin
            send_frame(FUNC_TONE, pick_sample(), pick_sample());
            budget--;
         end else if (pick < 97) begin
            send_frame(FUNC_RESTART, pick_sample(), pick_sample());
            budget--;
         end else begin
            send_frame(FUNC_UNUSED, pick_sample(), pick_sample());
         end
      end
      steady = 1'b0;
   endtask

   initial begin : stimulus
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_VOLUME;
      csr_wr_data       <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.func     <= FUNC_PCM;
      req_chan.left_in  <= '0;
      req_chan.right_in <= '0;
      gain_pct    = RESET_VOLUME;
      mono_on     = 1'b0;
      tone_incr   = RESET_STEP;
      tone_len    = RESET_LENGTH;
      tone_phase  = '0;
      frames_left = '0;

      add_checked(FUNC_PCM, 16'sh7FFF, 16'sh8000, 16'sd16383, -16'sd16384, 1'b0);
      add_checked(FUNC_TONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      add_checked(FUNC_PCM, -16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b0);
      add_checked(FUNC_PCM, -16'sd3, 16'sd3, -16'sd1, 16'sd1, 1'b0);
      add_frame(FUNC_UNUSED, 16'shFFFF, 16'shFFFF);
      add_frame(FUNC_RESTART, 16'sd0, 16'sd0);
      add_checked(FUNC_TONE, 16'sd0, 16'sd0, -16'sd3000, -16'sd3000, 1'b0);
      add_frame(FUNC_TONE, 16'sd0, 16'sd0);
      add_csr(CSR_VOLUME, 32'h0000_007F);
      add_csr(CSR_MONO_MODE, 32'h0000_0001);
      add_csr(CSR_PHASE_STEP, 32'h8000_0000);
      add_csr(CSR_TONE_LENGTH, 32'h0000_0002);
      add_frame(FUNC_RESTART, 16'sd0, 16'sd0);
      add_checked(FUNC_TONE, 16'sd0, 16'sd0, 16'sd6000, 16'sd6000, 1'b0);
      add_checked(FUNC_TONE, 16'sd0, 16'sd0, -16'sd6000, -16'sd6000, 1'b1);
      add_checked(FUNC_TONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      add_checked(FUNC_PCM, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0);
      add_checked(FUNC_PCM, 16'sh8000, 16'sd12345, 16'sh8000, 16'sh8000, 1'b0);
      add_csr(CSR_VOLUME, 32'h0000_0000);
      add_csr(CSR_SPARE_LO, 32'h0000_007F);
      add_csr(CSR_SPARE_HI, 32'hFFFF_FFFF);
      add_csr(CSR_MONO_MODE, 32'h0000_0000);
      add_csr(CSR_TONE_LENGTH, 32'h00FF_FFFF);
      add_csr(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      add_checked(FUNC_PCM, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 1'b0);
      add_frame(FUNC_RESTART, 16'sd0, 16'sd0);
      add_checked(FUNC_TONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
      add_csr(CSR_VOLUME, 32'h0000_0001);
      add_csr(CSR_PHASE_STEP, 32'h0000_0000);
      add_frame(FUNC_TONE, 16'sd0, 16'sd0);
      add_checked(FUNC_PCM, 16'sh8000, 16'sh7FFF, -16'sd327, 16'sd327, 1'b0);
      add_csr(CSR_TONE_LENGTH, 32'h0000_0000);
      add_frame(FUNC_RESTART, 16'sd0, 16'sd0);
      add_checked(FUNC_TONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      add_csr(CSR_VOLUME, 32'h0000_0065);
      add_checked(FUNC_PCM, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      add_checked(FUNC_PCM, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0);
      add_checked(FUNC_TONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (i == 0 || directed_rows[i-1].kind != ROW_CSR)
               drain_block();
            write_csr(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_frame(directed_rows[i].func, directed_rows[i].left, directed_rows[i].right,
                       directed_rows[i].known, directed_rows[i].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++)
         run_random_phase(phase);

      drain_block();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : drive_rsp_ready
      int held;
      held = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            held++;
            if (held == HOLD_CYCLES) begin
               hold_rsp = 1'b0;
               held     = 0;
            end
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin : check_responses
      frame_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected transaction: L=%0d R=%0d done=%0b",
                        rsp_chan.left_out, rsp_chan.right_out, rsp_chan.tone_done);
         end else begin
            want = pending_frames.pop_front();
            if (rsp_chan.left_out !== want.left || rsp_chan.right_out !== want.right ||
                rsp_chan.tone_done !== want.done) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("frame mismatch: expected L=%0d R=%0d done=%0b, got L=%0d R=%0d done=%0b",
                           want.left, want.right, want.done,
                           rsp_chan.left_out, rsp_chan.right_out, rsp_chan.tone_done);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
